/* rtl/core/mstt_pkg.sv */
// Shared types, constants and codes of the multi-slot task timer.
`timescale 1ns / 1ps

package mstt_pkg;

    // Table geometry.
    localparam int SLOTS      = 16;
    localparam int DELAY_BITS = 24;
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Fixed payload widths.
    localparam int REQ_W   = 3;
    localparam int DELAY_W = 24;
    localparam int ID_W    = 16;
    localparam int KIND_W  = 3;

    typedef logic [DELAY_BITS-1:0] t_delay;
    typedef logic [ID_W-1:0]       t_ident;
    typedef logic [CNT_W-1:0]      t_count;
    typedef logic [IDX_W-1:0]      t_index;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_ONCE     = 3'd0,
        REQ_PERIODIC = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_TICK     = 3'd3,
        REQ_CLEAR    = 3'd4
    } t_req_type;

    // Result codes.
    typedef enum logic [KIND_W-1:0] {
        EVT_SCHEDULED = 3'd0,
        EVT_REMOVED   = 3'd1,
        EVT_FIRED     = 3'd2,
        EVT_IDLE_TICK = 3'd3,
        EVT_CLEARED   = 3'd4
    } t_evt_kind;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

    // One timer slot.
    typedef struct packed {
        logic   periodic;
        t_delay remaining;
        t_delay reload;
        t_ident ident;
    } t_slot;

    // One pending result.
    typedef struct packed {
        t_evt_kind kind;
        t_ident    ident;
        logic      ok;
    } t_evt;

    // Control into the slot unit.
    typedef struct packed {
        logic   is_tick;
        logic   found;
        t_ident target;
    } t_slot_ctl;

    // Verdict from the slot unit.
    typedef struct packed {
        logic  fire;
        logic  keep;
        logic  hit;
        t_slot next;
    } t_slot_res;

endpackage

/* rtl/core/mstt_req_if.sv */
// Request channel of the multi-slot task timer.
`timescale 1ns / 1ps

interface mstt_req_if;
    logic                         valid;
    logic                         ready;
    logic [mstt_pkg::REQ_W-1:0]   req_type;
    logic [mstt_pkg::DELAY_W-1:0] delay_ms;
    logic [mstt_pkg::ID_W-1:0]    target_id;

    modport source (output valid, req_type, delay_ms, target_id, input ready);
    modport sink   (input valid, req_type, delay_ms, target_id, output ready);
endinterface

/* rtl/core/mstt_evt_if.sv */
// Result channel of the multi-slot task timer.
`timescale 1ns / 1ps

interface mstt_evt_if;
    logic                        valid;
    logic                        ready;
    logic [mstt_pkg::KIND_W-1:0] event_kind;
    logic [mstt_pkg::ID_W-1:0]   task_id;
    logic                        ok;
    logic                        last;

    modport source (output valid, event_kind, task_id, ok, last, input ready);
    modport sink   (input valid, event_kind, task_id, ok, last, output ready);
endinterface

/* rtl/core/mstt_slot_alu.sv */
// Shared slot unit: decrement, fire test, reload and remove match for one slot.
`timescale 1ns / 1ps

module mstt_slot_alu (
    input  mstt_pkg::t_slot     i_slot,
    input  mstt_pkg::t_slot_ctl i_ctl,
    output mstt_pkg::t_slot_res o_res
);
    import mstt_pkg::*;

    t_delay dec;
    logic   at_zero;
    logic   hit;

    // Saturating decrement of the remaining count.
    assign dec     = (i_slot.remaining != '0) ? i_slot.remaining - t_delay'(1) : '0;
    assign at_zero = (dec == '0);

    // Only the oldest slot carrying the target id is removed.
    assign hit = !i_ctl.is_tick && !i_ctl.found && (i_slot.ident == i_ctl.target);

    // A fired slot reloads if periodic and is dropped otherwise.
    always_comb begin
        o_res.next = i_slot;
        o_res.hit  = hit;
        o_res.fire = 1'b0;
        o_res.keep = !hit;
        if (i_ctl.is_tick) begin
            o_res.fire           = at_zero;
            o_res.keep           = !at_zero || i_slot.periodic;
            o_res.next.remaining = at_zero ? i_slot.reload : dec;
        end
    end
endmodule

/* rtl/core/multi_slot_task_timer_core.sv */
// Top level of the multi-slot task timer: slot table, sequencer and result register.
//
//  Channel  | Direction | Handshake     | Payload
//  ---------+-----------+---------------+----------------------------------------
//  i_req    | in        | valid / ready | req_type, delay_ms, target_id
//  o_evt    | out       | valid / ready | event_kind, task_id, ok, last
//
// Schedule and clear requests go from idle to the final state, which pushes their
// result into the result register once that register is free. Remove and tick
// requests walk the live slots one per cycle through the shared slot unit, save
// where a tick stalls, then go to the final state, which pushes the final result in
// the same way. Within the walk, a tick stalls only when a fire result meets a held
// fire result and a full result register.
// A synchronous reset empties the table and zeroes the id counter at once.
// i_req.ready is high only while the sequencer waits for a request.
`timescale 1ns / 1ps

module multi_slot_task_timer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mstt_req_if.sink   i_req,
    mstt_evt_if.source o_evt
);
    import mstt_pkg::*;

    // Slot table and control registers.
    t_slot     r_slot [SLOTS];
    t_state    r_state, n_state;
    t_count    r_count, n_count;
    t_count    r_idx, n_idx;
    t_count    r_w, n_w;
    t_ident    r_next_id, n_next_id;
    logic      r_is_tick, n_is_tick;
    logic      r_found, n_found;
    t_ident    r_target, n_target;
    logic      r_hold_v, n_hold_v;
    t_evt      r_hold, n_hold;
    logic      r_ov, n_ov;
    t_evt      r_out, n_out;
    logic      r_out_last, n_out_last;

    logic      wr_en;
    t_index    wr_idx;
    t_slot     wr_data;
    logic      accept;
    logic      out_busy;
    t_slot     rd_slot;
    t_slot_ctl alu_ctl;
    t_slot_res alu_res;

    assign accept   = i_req.valid && i_req.ready;
    assign out_busy = r_ov && !o_evt.ready;
    assign rd_slot  = r_slot[r_idx[IDX_W-1:0]];

    assign alu_ctl.is_tick = r_is_tick;
    assign alu_ctl.found   = r_found;
    assign alu_ctl.target  = r_target;

    mstt_slot_alu u_alu (
        .i_slot (rd_slot),
        .i_ctl  (alu_ctl),
        .o_res  (alu_res)
    );

    // Port drive.
    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_evt.valid      = r_ov;
    assign o_evt.event_kind = r_out.kind;
    assign o_evt.task_id    = r_out.ident;
    assign o_evt.ok         = r_out.ok;
    assign o_evt.last       = r_out_last;

    // Sequencer: next state, table writes and result pushes.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_w        = r_w;
        n_next_id  = r_next_id;
        n_is_tick  = r_is_tick;
        n_found    = r_found;
        n_target   = r_target;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_ov       = r_ov && !o_evt.ready;
        n_out      = r_out;
        n_out_last = r_out_last;
        wr_en      = 1'b0;
        wr_idx     = r_w[IDX_W-1:0];
        wr_data    = alu_res.next;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_idx     = '0;
                    n_w       = '0;
                    n_found   = 1'b0;
                    n_hold_v  = 1'b0;
                    n_target  = i_req.target_id;
                    n_is_tick = (i_req.req_type == REQ_TICK);
                    case (i_req.req_type)
                        REQ_ONCE, REQ_PERIODIC: begin
                            n_state = ST_FIN;
                            if (r_count >= t_count'(SLOTS)) begin
                                n_hold = '{kind: EVT_SCHEDULED, ident: '0, ok: 1'b0};
                            end else begin
                                wr_en             = 1'b1;
                                wr_idx            = r_count[IDX_W-1:0];
                                wr_data.periodic  = (i_req.req_type == REQ_PERIODIC);
                                wr_data.remaining = t_delay'(i_req.delay_ms);
                                wr_data.reload    = t_delay'(i_req.delay_ms);
                                wr_data.ident     = r_next_id;
                                n_count           = r_count + t_count'(1);
                                n_next_id         = r_next_id + t_ident'(1);
                                n_hold = '{kind: EVT_SCHEDULED, ident: r_next_id, ok: 1'b1};
                            end
                        end
                        REQ_REMOVE, REQ_TICK: begin
                            n_state = ST_SCAN;
                        end
                        REQ_CLEAR: begin
                            n_state   = ST_FIN;
                            n_count   = '0;
                            n_next_id = '0;
                            n_hold    = '{kind: EVT_CLEARED, ident: '0, ok: 1'b1};
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx == r_count) begin
                    // Walk done: close the table and prepare the final result.
                    n_count = r_w;
                    n_state = ST_FIN;
                    if (!r_is_tick) begin
                        n_hold = '{kind: EVT_REMOVED, ident: r_target, ok: r_found};
                    end else if (!r_hold_v) begin
                        n_hold = '{kind: EVT_IDLE_TICK, ident: '0, ok: 1'b1};
                    end
                end else if (!(alu_res.fire && r_hold_v && out_busy)) begin
                    // One slot per cycle unless stalled; kept slots move down to the write index.
                    if (alu_res.keep) begin
                        wr_en = 1'b1;
                        n_w   = r_w + t_count'(1);
                    end
                    if (alu_res.hit) begin
                        n_found = 1'b1;
                    end
                    if (alu_res.fire) begin
                        if (r_hold_v) begin
                            n_ov       = 1'b1;
                            n_out      = r_hold;
                            n_out_last = 1'b0;
                        end
                        n_hold_v = 1'b1;
                        n_hold   = '{kind: EVT_FIRED, ident: rd_slot.ident, ok: 1'b1};
                    end
                    n_idx = r_idx + t_count'(1);
                end
            end
            ST_FIN: begin
                // The held result is the final one of this request.
                if (!out_busy) begin
                    n_ov       = 1'b1;
                    n_out      = r_hold;
                    n_out_last = 1'b1;
                    n_hold_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_next_id <= '0;
            r_hold_v  <= 1'b0;
            r_ov      <= 1'b0;
            r_idx     <= '0;
            r_w       <= '0;
            r_found   <= 1'b0;
            r_is_tick <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_next_id <= n_next_id;
            r_hold_v  <= n_hold_v;
            r_ov      <= n_ov;
            r_idx     <= n_idx;
            r_w       <= n_w;
            r_found   <= n_found;
            r_is_tick <= n_is_tick;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_target   <= n_target;
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    // Slot table write port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[wr_idx] <= wr_data;
        end
    end

    // The live count never exceeds the table.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(SLOTS))
        else $error("live slot count exceeds table size");

    // Compaction never writes ahead of the read index.
    a_write_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_w <= r_idx))
        else $error("compaction write index passed read index");

    // Leaving the final state always presents a result marked last.
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !out_busy) |=> (r_ov && r_out_last && r_state == ST_IDLE))
        else $error("final result not presented with last");

    // A clear empties the table and restarts the id counter.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_CLEAR) |=> (r_count == '0 && r_next_id == '0))
        else $error("clear did not empty the table");

    // An unknown request leaves the block idle with no new result.
    a_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type > REQ_CLEAR)
        |=> (r_state == ST_IDLE && $stable(r_count)))
        else $error("unknown request changed state");
endmodule
